// File: rtl/core/a51_keystream_generator_macros.svh
// Assertion macros for the A5/1 keystream generator.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef A51_KEYSTREAM_GENERATOR_MACROS_SVH
`define A51_KEYSTREAM_GENERATOR_MACROS_SVH

// same-cycle implication
`define A51_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define A51_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/a51_pkg.sv
// Shared types, constants, LFSR functions and microcode ROM for the A5/1 generator.
// No dependencies.
package a51_pkg;

    localparam int KEY_BITS    = 64;
    localparam int FRAME_BITS  = 22;
    localparam int MIX_STEPS   = 100;
    localparam int BLOCK_BITS  = 114;
    localparam int CNT_W       = 7;
    localparam int PC_W        = 3;
    localparam int ADDR_W      = 4;

    localparam logic [18:0] TAPS_A = 19'h72000;
    localparam logic [21:0] TAPS_B = 22'h300000;
    localparam logic [22:0] TAPS_C = 23'h700080;

    localparam int MID_A = 8;
    localparam int MID_B = 10;
    localparam int MID_C = 10;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BLOCK_BITS - 1);

    // step addresses of the control program
    localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] PC_CLEAR = 3'd1;
    localparam logic [PC_W-1:0] PC_KEY   = 3'd2;
    localparam logic [PC_W-1:0] PC_FRAME = 3'd3;
    localparam logic [PC_W-1:0] PC_MIX   = 3'd4;
    localparam logic [PC_W-1:0] PC_GEN0  = 3'd5;
    localparam logic [PC_W-1:0] PC_GEN1  = 3'd6;

    // register address of cipher_key
    localparam logic ADDR_KEY = 1'b0;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_LOAD_KEY,
        OP_LOAD_FRAME,
        OP_MIX,
        OP_GEN
    } t_op;

    typedef enum logic {
        JMP_START,
        JMP_COUNT
    } t_jmp;

    typedef struct packed {
        t_op              op;
        t_jmp             jmp;
        logic [CNT_W-1:0] last_cnt;
        logic             dir;
        logic [PC_W-1:0]  next_pc;
    } t_uword;

    typedef struct packed {
        t_op              op;
        logic             dir;
        logic [CNT_W-1:0] index;
    } t_dp_ctl;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_IDLE, jmp: JMP_START, last_cnt: '0, dir: 1'b0, next_pc: PC_CLEAR};
        case (pc)
            PC_IDLE:  w = '{OP_IDLE,       JMP_START, '0, 1'b0, PC_CLEAR};
            PC_CLEAR: w = '{OP_CLEAR,      JMP_COUNT, '0, 1'b0, PC_KEY};
            PC_KEY:   w = '{OP_LOAD_KEY,   JMP_COUNT, CNT_W'(KEY_BITS - 1),   1'b0, PC_FRAME};
            PC_FRAME: w = '{OP_LOAD_FRAME, JMP_COUNT, CNT_W'(FRAME_BITS - 1), 1'b0, PC_MIX};
            PC_MIX:   w = '{OP_MIX,        JMP_COUNT, CNT_W'(MIX_STEPS - 1),  1'b0, PC_GEN0};
            PC_GEN0:  w = '{OP_GEN,        JMP_COUNT, LAST_BIT, 1'b0, PC_GEN1};
            PC_GEN1:  w = '{OP_GEN,        JMP_COUNT, LAST_BIT, 1'b1, PC_IDLE};
            default:  w = '{OP_IDLE,       JMP_COUNT, '0, 1'b0, PC_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [18:0] shift_a(input logic [18:0] r);
        return {r[17:0], ^(r & TAPS_A)};
    endfunction

    function automatic logic [21:0] shift_b(input logic [21:0] r);
        return {r[20:0], ^(r & TAPS_B)};
    endfunction

    function automatic logic [22:0] shift_c(input logic [22:0] r);
        return {r[21:0], ^(r & TAPS_C)};
    endfunction

endpackage

// File: rtl/core/a51_seq.sv
// Microcode sequencer: program counter, step counter and control ROM.
// Depends on a51_pkg.
module a51_seq
    import a51_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    output t_dp_ctl o_ctl
);

    logic [PC_W-1:0]  r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_uword           w_uw;

    always_comb begin
        w_uw  = ucode(r_pc);
        n_pc  = r_pc;
        n_cnt = r_cnt;
        case (w_uw.jmp)
            JMP_START: begin
                if (i_start) begin
                    n_pc = w_uw.next_pc;
                end
                n_cnt = '0;
            end
            JMP_COUNT: begin
                if (r_cnt == w_uw.last_cnt) begin
                    n_pc  = w_uw.next_pc;
                    n_cnt = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_pc  = PC_IDLE;
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_IDLE;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    assign o_busy = (r_pc != PC_IDLE);
    assign o_ctl  = '{op: w_uw.op, dir: w_uw.dir, index: r_cnt};

endmodule

// File: rtl/core/a51_dp.sv
// Datapath: the three LFSRs, bit loading, majority clocking and byte packing.
// Depends on a51_pkg; driven by the control word from a51_seq.
module a51_dp
    import a51_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [21:0] i_frame_number,
    input  logic [63:0] i_key,
    input  t_dp_ctl     i_ctl,
    output logic        o_valid,
    output logic        o_direction,
    output logic [3:0]  o_byte_index,
    output logic [7:0]  o_keystream_byte,
    output logic        o_last
);

    logic [18:0] r_a, n_a, w_sh_a;
    logic [21:0] r_b, n_b, w_sh_b;
    logic [22:0] r_c, n_c, w_sh_c;
    logic [21:0] r_frame;
    logic [31:0] w_frame_pad;
    logic [7:0]  r_acc, n_acc;
    logic        w_bit, w_maj, w_ob, w_emit;
    logic [2:0]  w_pos;
    logic        r_valid, r_dir, r_last;
    logic [3:0]  r_idx;
    logic [7:0]  r_byte;

    assign w_sh_a      = shift_a(r_a);
    assign w_sh_b      = shift_b(r_b);
    assign w_sh_c      = shift_c(r_c);
    assign w_frame_pad = {10'b0, r_frame};
    assign w_maj       = (r_a[MID_A] & r_b[MID_B]) | (r_a[MID_A] & r_c[MID_C]) |
                         (r_b[MID_B] & r_c[MID_C]);
    assign w_pos       = i_ctl.index[2:0];

    always_comb begin
        n_a   = r_a;
        n_b   = r_b;
        n_c   = r_c;
        w_bit = 1'b0;
        case (i_ctl.op)
            OP_CLEAR: begin
                n_a = '0;
                n_b = '0;
                n_c = '0;
            end
            OP_LOAD_KEY, OP_LOAD_FRAME: begin
                w_bit = (i_ctl.op == OP_LOAD_KEY) ? i_key[i_ctl.index[5:0]]
                                                  : w_frame_pad[i_ctl.index[4:0]];
                n_a = {w_sh_a[18:1], w_sh_a[0] ^ w_bit};
                n_b = {w_sh_b[21:1], w_sh_b[0] ^ w_bit};
                n_c = {w_sh_c[22:1], w_sh_c[0] ^ w_bit};
            end
            OP_MIX, OP_GEN: begin
                if (r_a[MID_A] == w_maj) n_a = w_sh_a;
                if (r_b[MID_B] == w_maj) n_b = w_sh_b;
                if (r_c[MID_C] == w_maj) n_c = w_sh_c;
            end
            default: begin
                n_a = r_a;
            end
        endcase
    end

    // keystream bit from the freshly clocked registers, packed MSB first
    assign w_ob   = n_a[18] ^ n_b[21] ^ n_c[22];
    assign n_acc  = (w_pos == 3'd0) ? {w_ob, 7'b0}
                                    : (r_acc | (8'({7'b0, w_ob}) << (3'd7 - w_pos)));
    assign w_emit = (i_ctl.op == OP_GEN) && ((w_pos == 3'd7) || (i_ctl.index == LAST_BIT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_a     <= n_a;
            r_b     <= n_b;
            r_c     <= n_c;
            r_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_frame <= i_frame_number;
        end
        if (i_ctl.op == OP_GEN) begin
            r_acc <= n_acc;
        end
        if (w_emit) begin
            r_dir  <= i_ctl.dir;
            r_idx  <= i_ctl.index[6:3];
            r_byte <= n_acc;
            r_last <= i_ctl.dir && (i_ctl.index == LAST_BIT);
        end
    end

    assign o_valid          = r_valid;
    assign o_direction      = r_dir;
    assign o_byte_index     = r_idx;
    assign o_keystream_byte = r_byte;
    assign o_last           = r_last;

endmodule

// File: rtl/core/a51_keystream_generator.sv
// Top level of the A5/1 keystream generator: APB key register, sequencer, datapath.
// Depends on a51_pkg, a51_seq, a51_dp and a51_keystream_generator_macros.svh.
//
// Usage:
//   Write the 64-bit cipher_key over the APB port at byte address 0 (pwdata is
//   64 bits, pready is always high) while busy is low. Pulse start with a frame
//   number on i_frame_number; it is taken at the edge where start is high and
//   busy is low.
//   The run steps through clear, loading of the 64 key bits and 22 frame bits,
//   mixing and two keystream passes of 114 bits each, stepped by the microcode
//   ROM in a51_seq. busy goes high after the start transfer and stays high
//   until the run ends; a new frame can be started only once busy is low again.
//   Results: 30 bytes, direction 0 bytes 0..14 then direction 1 bytes 0..14,
//   each shown for one cycle with o_valid. The final byte (o_last) shows in
//   the first cycle busy is low again. Byte 14 carries two bits in its MSBs.
//   The receiver cannot stall the output; it must take every o_valid cycle.
//   Reset clears the key to zero, the LFSRs and the sequencer (back to idle).
`include "a51_keystream_generator_macros.svh"
module a51_keystream_generator
    import a51_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [21:0]       i_frame_number,
    output logic              o_valid,
    output logic              o_direction,
    output logic [3:0]        o_byte_index,
    output logic [7:0]        o_keystream_byte,
    output logic              o_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [63:0] r_key;
    logic        w_accept;
    logic        w_key_sel;
    t_dp_ctl     w_ctl;

    assign pready    = 1'b1;
    assign w_key_sel = (paddr[3] == ADDR_KEY);
    assign prdata    = w_key_sel ? r_key : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (psel && penable && pwrite && w_key_sel) begin
            r_key <= pwdata;
        end
    end

    assign w_accept = start && !busy;

    a51_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_ctl   (w_ctl)
    );

    a51_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_frame_number   (i_frame_number),
        .i_key            (r_key),
        .i_ctl            (w_ctl),
        .o_valid          (o_valid),
        .o_direction      (o_direction),
        .o_byte_index     (o_byte_index),
        .o_keystream_byte (o_keystream_byte),
        .o_last           (o_last)
    );

    `A51_ASSERT_NEXT(a_start_busy, w_accept, busy, "accepted frame did not start a run")
    `A51_ASSERT_NOW(a_last_done, o_last && o_valid,
        !busy && o_direction && (o_byte_index == 4'd14),
        "last byte out of step with end of run")
    `A51_ASSERT_NOW(a_mid_busy, o_valid && !o_last, busy, "byte emitted outside a run")
    `A51_ASSERT_NOW(a_tail_bits, o_valid && (o_byte_index == 4'd14),
        o_keystream_byte[5:0] == 6'd0, "final byte has stray low bits")

endmodule
